@@ rtl/core/sfm_pkg.sv @@
// Shared constants, types and twiddle functions for the STFT magnitude block.
// No dependencies; every other file of the block imports this package.
package sfm_pkg;

   localparam int FRAME_LEN  = 64;
   localparam int PTR_W      = $clog2(FRAME_LEN);
   localparam int CNT_W      = 7;
   localparam int ANGLES     = 64;
   localparam int ANGLE_W    = $clog2(ANGLES);
   localparam int ANGLE_STEP = ANGLES / FRAME_LEN;
   localparam int NUM_BINS   = FRAME_LEN / 2 + 1;
   localparam int BIN_W      = 6;
   localparam int FRAME_W    = 16;
   localparam int MAG_W      = 22;
   localparam int ACC_W      = 24;
   localparam int SQ_W       = 48;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   localparam logic [1:0] CSR_HOP_SIZE        = 2'd0;
   localparam logic [1:0] CSR_FRAMES_PER_CLIP = 2'd1;

   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [PTR_W-1:0]   head;
   } job_type;

   typedef struct packed {
      logic               ring_we;
      logic [PTR_W-1:0]   ring_addr;
      logic signed [15:0] sample;
      logic               win_we;
      logic [PTR_W-1:0]   win_addr;
      logic [15:0]        coef;
   } store_wr_type;

   // Cosine for the first quarter turn, Q1.15.
   function automatic logic signed [16:0] quarter_cos(input logic [4:0] i);
      logic signed [16:0] r;
      case (i)
         5'd0:    r = 17'sd32768;
         5'd1:    r = 17'sd32610;
         5'd2:    r = 17'sd32138;
         5'd3:    r = 17'sd31357;
         5'd4:    r = 17'sd30274;
         5'd5:    r = 17'sd28899;
         5'd6:    r = 17'sd27246;
         5'd7:    r = 17'sd25330;
         5'd8:    r = 17'sd23170;
         5'd9:    r = 17'sd20788;
         5'd10:   r = 17'sd18205;
         5'd11:   r = 17'sd15447;
         5'd12:   r = 17'sd12540;
         5'd13:   r = 17'sd9512;
         5'd14:   r = 17'sd6393;
         5'd15:   r = 17'sd3212;
         default: r = 17'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [16:0] cos_at(input logic [ANGLE_W-1:0] m);
      logic signed [16:0] r;
      if (m <= 6'd16) begin
         r = quarter_cos(5'(m));
      end else if (m <= 6'd32) begin
         r = -quarter_cos(5'(6'd32 - m));
      end else if (m <= 6'd48) begin
         r = -quarter_cos(5'(m - 6'd32));
      end else begin
         r = quarter_cos(5'(7'd64 - {1'b0, m}));
      end
      return r;
   endfunction

   function automatic logic signed [16:0] sin_at(input logic [ANGLE_W-1:0] m);
      return cos_at(ANGLE_W'(6'd16 - m));
   endfunction

endpackage

@@ rtl/core/sfm_channels.sv @@
// Valid/ready channel interfaces for the sample input and the magnitude output.
// Depends on sfm_pkg for field widths.
interface sfm_req_if import sfm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic               first_of_clip;
   logic signed [15:0] sample;
   logic [5:0]         entry_index;
   logic [15:0]        coefficient;

   modport source (output valid, kind, first_of_clip, sample, entry_index, coefficient,
                   input ready);
   modport sink   (input valid, kind, first_of_clip, sample, entry_index, coefficient,
                   output ready);
endinterface

interface sfm_rsp_if import sfm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_index;
   logic [BIN_W-1:0]   bin_index;
   logic [MAG_W-1:0]   magnitude;
   logic               last_bin;

   modport source (output valid, frame_index, bin_index, magnitude, last_bin, input ready);
   modport sink   (input valid, frame_index, bin_index, magnitude, last_bin, output ready);
endinterface

@@ rtl/core/sfm_store.sv @@
// Sample ring and window table memories, one write and one registered read each.
// Depends on sfm_pkg.
module sfm_store import sfm_pkg::*; (
   input  logic               clock,
   input  store_wr_type       wr,
   input  logic [PTR_W-1:0]   ring_raddr,
   input  logic [PTR_W-1:0]   win_raddr,
   output logic signed [15:0] ring_rdata,
   output logic [15:0]        win_rdata
);

   logic signed [15:0] ring_mem [FRAME_LEN];
   logic [15:0]        win_mem  [FRAME_LEN];
   logic signed [15:0] ring_rd_ff;
   logic [15:0]        win_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.ring_we) begin
         ring_mem[wr.ring_addr] <= wr.sample;
      end
      if (wr.win_we) begin
         win_mem[wr.win_addr] <= wr.coef;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
      win_rd_ff  <= win_mem[win_raddr];
   end

   assign ring_rdata = ring_rd_ff;
   assign win_rdata  = win_rd_ff;

endmodule

@@ rtl/core/sfm_queue.sv @@
// Short queue of frame jobs between the front and the back.
// Depends on sfm_pkg.
module sfm_queue import sfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   job_type                q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_W:0]       count_ff, count_in;
   logic                   do_pop;

   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign head_job = q_mem[rd_ff];

   always_comb begin
      wr_in    = push ? Q_PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? Q_PTR_W'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/sfm_front.sv @@
// Input front end: configuration registers, fill and hop counters, frame decision.
// Depends on sfm_pkg and the sfm_req_if channel.
module sfm_front import sfm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sfm_req_if.sink      req_bus,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         back_busy,
   input  logic         q_empty,
   output logic         job_push,
   output job_type      job,
   output store_wr_type wr
);

   logic [6:0]         hop_ff, hop_in;
   logic [15:0]        fpc_ff, fpc_in;
   logic [CNT_W-1:0]   filled_ff, filled_in, since_ff, since_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PTR_W-1:0]   wptr_ff, wptr_in;

   logic               accept, sample_acc, fire;
   logic [CNT_W-1:0]   f0, s0, filled_nx, since_nx;
   logic [FRAME_W-1:0] fc0;

   // Nothing is taken while a frame is queued or being transformed, so the
   // ring and the window table stay still under the back end's reads.
   assign req_bus.ready = q_empty && !back_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign sample_acc    = accept && (req_bus.kind == KIND_SAMPLE);

   always_comb begin
      f0  = req_bus.first_of_clip ? '0 : filled_ff;
      s0  = req_bus.first_of_clip ? '0 : since_ff;
      fc0 = req_bus.first_of_clip ? '0 : frame_ff;
      filled_nx = (f0 < CNT_W'(FRAME_LEN)) ? CNT_W'(f0 + 1'b1) : f0;
      since_nx  = (s0 != {CNT_W{1'b1}}) ? CNT_W'(s0 + 1'b1) : s0;
      fire = (filled_nx == CNT_W'(FRAME_LEN)) && (fc0 < fpc_ff) &&
             ((fc0 == '0) || (since_nx >= hop_ff));

      filled_in = filled_ff;
      since_in  = since_ff;
      frame_in  = frame_ff;
      wptr_in   = wptr_ff;
      if (sample_acc) begin
         filled_in = filled_nx;
         since_in  = fire ? '0 : since_nx;
         frame_in  = fire ? FRAME_W'(fc0 + 1'b1) : fc0;
         wptr_in   = PTR_W'(wptr_ff + 1'b1);
      end

      hop_in = hop_ff;
      fpc_in = fpc_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HOP_SIZE:        hop_in = csr_wdata[6:0];
            CSR_FRAMES_PER_CLIP: fpc_in = csr_wdata;
            default:             ;
         endcase
      end

      job_push  = sample_acc && fire;
      job.frame = fc0;
      job.head  = PTR_W'(wptr_ff + 1'b1);

      wr.ring_we   = sample_acc;
      wr.ring_addr = wptr_ff;
      wr.sample    = req_bus.sample;
      wr.win_we    = accept && (req_bus.kind == KIND_WINDOW) &&
                     ({1'b0, req_bus.entry_index} < 7'(FRAME_LEN));
      wr.win_addr  = PTR_W'(req_bus.entry_index);
      wr.coef      = req_bus.coefficient;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff    <= 7'd32;
         fpc_ff    <= 16'd499;
         filled_ff <= '0;
         since_ff  <= '0;
         frame_ff  <= '0;
         wptr_ff   <= '0;
      end else begin
         hop_ff    <= hop_in;
         fpc_ff    <= fpc_in;
         filled_ff <= filled_in;
         since_ff  <= since_in;
         frame_ff  <= frame_in;
         wptr_ff   <= wptr_in;
      end
   end

endmodule

@@ rtl/core/sfm_back.sv @@
// Back end: windowing, per-bin DFT accumulation, squared magnitude, bit-serial
// square root and the result register. Depends on sfm_pkg and sfm_rsp_if.
module sfm_back import sfm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  job_type            q_job,
   output logic               q_pop,
   output logic               back_busy,
   output logic [PTR_W-1:0]   ring_raddr,
   output logic [PTR_W-1:0]   win_raddr,
   input  logic signed [15:0] ring_rdata,
   input  logic [15:0]        win_rdata,
   sfm_rsp_if.source          rsp_bus
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ACC  = 6'b000010,
      ST_SQ   = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_ROOT = 6'b010000,
      ST_OUT  = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   job_type            job_ff, job_in;
   logic [BIN_W-1:0]   k_ff, k_in;
   logic [PTR_W:0]     n_ff, n_in;
   logic [ANGLE_W-1:0] m_ff, m_in, mstep;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic l1_ff, l1_in, l2_ff, l2_in, l3_ff, l3_in, l4_ff, l4_in;
   logic [ANGLE_W-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic signed [32:0] p2_ff, p2_in;
   logic signed [17:0] x3_ff, x3_in;
   logic signed [16:0] c3_ff, c3_in, s3_ff, s3_in;
   logic signed [34:0] pc4_ff, pc4_in, ps4_ff, ps4_in;
   logic signed [ACC_W-1:0] re_ff, re_in, im_ff, im_in, tc, ts;
   logic signed [SQ_W-1:0]  sqre_ff, sqre_in, sqim_ff, sqim_in;
   logic [SQ_W-1:0]    rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in, trial;

   logic               out_v_ff, out_v_in, load;
   logic [FRAME_W-1:0] out_frame_ff, out_frame_in;
   logic [BIN_W-1:0]   out_bin_ff, out_bin_in;
   logic [MAG_W-1:0]   out_mag_ff, out_mag_in;
   logic               out_last_ff, out_last_in;
   logic               issuing, bin_start;

   assign back_busy  = (state_ff != ST_IDLE);
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;
   assign mstep      = ANGLE_W'(k_ff * ANGLE_STEP);
   assign issuing    = (state_ff == ST_ACC) && (n_ff < (PTR_W+1)'(FRAME_LEN));
   assign ring_raddr = PTR_W'(job_ff.head + n_ff[PTR_W-1:0]);
   assign win_raddr  = n_ff[PTR_W-1:0];
   assign load       = (state_ff == ST_OUT) && (!out_v_ff || rsp_bus.ready);
   assign trial      = root_ff + bit_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      k_in      = k_ff;
      bin_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               job_in    = q_job;
               k_in      = '0;
               bin_start = 1'b1;
               state_in  = ST_ACC;
            end
         end
         ST_ACC: begin
            if (v4_ff && l4_ff) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load) begin
               if (k_ff == BIN_W'(NUM_BINS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in      = BIN_W'(k_ff + 1'b1);
                  bin_start = 1'b1;
                  state_in  = ST_ACC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Address issue: one sample per cycle for the current bin.
      n_in  = bin_start ? '0 : (issuing ? (PTR_W+1)'(n_ff + 1'b1) : n_ff);
      m_in  = bin_start ? '0 : (issuing ? ANGLE_W'(m_ff + mstep) : m_ff);
      v1_in = issuing;
      l1_in = issuing && (n_ff == (PTR_W+1)'(FRAME_LEN - 1));
      m1_in = m_ff;

      // Window product, then rounding and twiddle lookup, then twiddle products.
      v2_in  = v1_ff;
      l2_in  = l1_ff;
      m2_in  = m1_ff;
      p2_in  = 33'(ring_rdata) * 33'(signed'({1'b0, win_rdata}));
      v3_in  = v2_ff;
      l3_in  = l2_ff;
      x3_in  = 18'((p2_ff + 33'sd16384) >>> 15);
      c3_in  = cos_at(m2_ff);
      s3_in  = sin_at(m2_ff);
      v4_in  = v3_ff;
      l4_in  = v3_ff && l3_ff;
      pc4_in = 35'(x3_ff) * 35'(c3_ff);
      ps4_in = 35'(x3_ff) * 35'(s3_ff);

      tc    = ACC_W'((pc4_ff + 35'sd16384) >>> 15);
      ts    = ACC_W'((ps4_ff + 35'sd16384) >>> 15);
      re_in = bin_start ? '0 : (v4_ff ? ACC_W'(re_ff + tc) : re_ff);
      im_in = bin_start ? '0 : (v4_ff ? ACC_W'(im_ff - ts) : im_ff);

      sqre_in = re_ff * re_ff;
      sqim_in = im_ff * im_ff;

      // Restoring square root, one result bit per cycle.
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (state_ff == ST_SUM) begin
         rem_in  = SQ_W'(sqre_ff) + SQ_W'(sqim_ff);
         root_in = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
      end else if (state_ff == ST_ROOT) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      out_v_in     = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_v_ff);
      out_frame_in = load ? job_ff.frame : out_frame_ff;
      out_bin_in   = load ? k_ff : out_bin_ff;
      out_last_in  = load ? (k_ff == BIN_W'(NUM_BINS - 1)) : out_last_ff;
      out_mag_in   = out_mag_ff;
      if (load) begin
         out_mag_in = (root_ff > SQ_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(root_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         n_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      m_ff         <= m_in;
      l1_ff        <= l1_in;
      l2_ff        <= l2_in;
      l3_ff        <= l3_in;
      l4_ff        <= l4_in;
      m1_ff        <= m1_in;
      m2_ff        <= m2_in;
      p2_ff        <= p2_in;
      x3_ff        <= x3_in;
      c3_ff        <= c3_in;
      s3_ff        <= s3_in;
      pc4_ff       <= pc4_in;
      ps4_ff       <= ps4_in;
      re_ff        <= re_in;
      im_ff        <= im_in;
      sqre_ff      <= sqre_in;
      sqim_ff      <= sqim_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      out_frame_ff <= out_frame_in;
      out_bin_ff   <= out_bin_in;
      out_mag_ff   <= out_mag_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.frame_index = out_frame_ff;
   assign rsp_bus.bin_index   = out_bin_ff;
   assign rsp_bus.magnitude   = out_mag_ff;
   assign rsp_bus.last_bin    = out_last_ff;

endmodule

@@ rtl/core/stft_magnitude_frames.sv @@
// An item that completes a frame yields all 33 bins of that frame. Throughput: one item per
// cycle while no frame is in work. Each bin passes its 64 samples through the window/twiddle
// pipeline, is squared and summed, takes the square root and is loaded into the output
// register; output stalls can hold up each bin. Reset clears counters, job queue and output
// register; sample and window memories are not.
module stft_magnitude_frames import sfm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sfm_req_if.sink     req_bus,
   sfm_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // The front end classifies each beat: window writes go straight to the
   // window table, samples go into the ring and advance the fill and hop
   // counters. When a sample completes a frame, a job carrying the frame
   // number and the ring position of the oldest sample enters the queue.
   logic               job_push, q_pop, q_empty, back_busy;
   job_type            push_job, q_job;
   store_wr_type       wr;
   logic [PTR_W-1:0]   ring_raddr, win_raddr;
   logic signed [15:0] ring_rdata;
   logic [15:0]        win_rdata;

   sfm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .back_busy (back_busy),
      .q_empty   (q_empty),
      .job_push  (job_push),
      .job       (push_job),
      .wr        (wr)
   );

   sfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (q_job),
      .empty    (q_empty)
   );

   sfm_store u_store (
      .clock      (clock),
      .wr         (wr),
      .ring_raddr (ring_raddr),
      .win_raddr  (win_raddr),
      .ring_rdata (ring_rdata),
      .win_rdata  (win_rdata)
   );

   // The back end runs each bin through the windowing and twiddle pipeline,
   // squares and sums the result, takes the root and hands each bin beat to
   // the output register, which holds it until the sink takes it.
   sfm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .back_busy  (back_busy),
      .ring_raddr (ring_raddr),
      .win_raddr  (win_raddr),
      .ring_rdata (ring_rdata),
      .win_rdata  (win_rdata),
      .rsp_bus    (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // A new frame job only enters an empty queue with the back end idle.
   a_push_alone: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (q_empty && !back_busy))
      else $error("frame job pushed while another is pending");

   // Once a frame is queued, the input is closed in the next cycle.
   a_stall_after_push: assert property (@(posedge clock) disable iff (reset)
      job_push |=> !req_bus.ready)
      else $error("input open while a frame is pending");

   // Bin numbers never run past the last real-spectrum bin.
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.bin_index <= BIN_W'(NUM_BINS - 1)))
      else $error("bin index out of range");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the STFT magnitude block: drives window and sample
// beats, predicts every bin magnitude and compares the result beats in order.
// Depends on sfm_pkg and the channel interfaces in sfm_channels.sv.
module testbench;
   import sfm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted beat before the run is declared hung, and the length in
   // cycles of the long receiver hold.
   localparam int HANG_LIMIT = 60000;
   localparam int LONG_HOLD  = 6000;

   typedef struct {
      logic               kind;
      logic               first_of_clip;
      logic signed [15:0] sample;
      logic [5:0]         entry_index;
      logic [15:0]        coefficient;
   } audio_beat_type;

   typedef struct {
      logic [FRAME_W-1:0] frame_index;
      logic [BIN_W-1:0]   bin_index;
      logic [MAG_W-1:0]   magnitude;
      logic               last_bin;
   } bin_mag_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   sfm_req_if req_bus ();
   sfm_rsp_if rsp_bus ();

   stft_magnitude_frames dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Beats waiting to be offered, and the magnitudes the block still owes us.
   audio_beat_type pending_beats[$];
   bin_mag_type    bins_due[$];
   int          error_count = 0;
   int          hold_requests = 0;
   int          holds_served = 0;

   // Our own copy of the block's state, updated on every accepted input beat.
   int          window_coef[FRAME_LEN];
   int          sample_hist[FRAME_LEN];
   int          fill_level;
   int          samples_since;
   int          frame_num;
   int          hop_cfg;
   int          clip_frames_cfg;

   initial begin
      clock = 1'b0;
   end
   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Cosine of 2*pi*m/64 in Q1.15, built by symmetry from one quarter turn.
   function automatic longint twiddle_cos(input int m);
      int q[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                    20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      int a;
      a = m & 63;
      if (a <= 16) return q[a];
      if (a <= 32) return -q[32 - a];
      if (a <= 48) return -q[a - 32];
      return q[64 - a];
   endfunction

   // Round a Q30 product to Q15: add half, then floor divide by 2^15.
   function automatic longint to_q15(input longint p);
      return (p + 64'sd16384) >>> 15;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Apply one accepted beat to the shadow state and queue the bins of any frame it
   // completes.
   task automatic predict_spectrum(input audio_beat_type b);
      longint   xw[FRAME_LEN];
      longint   re;
      longint   im;
      longint unsigned mag;
      bit       fire;
      bin_mag_type r;
      if (b.kind == KIND_WINDOW) begin
         if (b.entry_index < FRAME_LEN) window_coef[b.entry_index] = b.coefficient;
         return;
      end
      if (b.first_of_clip) begin
         fill_level = 0;
         samples_since = 0;
         frame_num = 0;
      end
      for (int n = 0; n < FRAME_LEN - 1; n++) sample_hist[n] = sample_hist[n + 1];
      sample_hist[FRAME_LEN - 1] = b.sample;
      if (fill_level < FRAME_LEN) fill_level++;
      if (samples_since < 127) samples_since++;
      fire = fill_level == FRAME_LEN && frame_num < clip_frames_cfg &&
             (frame_num == 0 || samples_since >= hop_cfg);
      if (!fire) return;
      for (int n = 0; n < FRAME_LEN; n++)
         xw[n] = to_q15(longint'(sample_hist[n]) * longint'(window_coef[n]));
      for (int k = 0; k <= FRAME_LEN / 2; k++) begin
         re = 0;
         im = 0;
         for (int n = 0; n < FRAME_LEN; n++) begin
            re += to_q15(xw[n] * twiddle_cos(k * n * ANGLE_STEP));
            im -= to_q15(xw[n] * twiddle_cos(16 - k * n * ANGLE_STEP));
         end
         mag = floor_sqrt(longint'(re * re + im * im));
         if (mag > MAG_MAX) mag = MAG_MAX;
         r.frame_index = frame_num[FRAME_W-1:0];
         r.bin_index   = k[BIN_W-1:0];
         r.magnitude   = mag[MAG_W-1:0];
         r.last_bin    = (k == FRAME_LEN / 2);
         bins_due.push_back(r);
      end
      samples_since = 0;
      frame_num = (frame_num + 1) & 16'hFFFF;
   endtask

   // Input driver: offers queued beats with a random gap before each one. In burst
   // stretches the gap is zero so that beats arrive back to back.
   int  send_gap;
   bit  send_burst;
   audio_beat_type on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
         send_burst <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // The beat on the bus must hold until the block takes it.
      end else begin
         if (req_bus.valid && req_bus.ready) predict_spectrum(on_bus);
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            on_bus = pending_beats.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.kind          <= on_bus.kind;
            req_bus.first_of_clip <= on_bus.first_of_clip;
            req_bus.sample        <= on_bus.sample;
            req_bus.entry_index   <= on_bus.entry_index;
            req_bus.coefficient   <= on_bus.coefficient;
            if ($urandom_range(0, 29) == 0) send_burst <= !send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, 18);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver and checker. A long hold, when asked for, keeps ready low so that
   // the frame in work backs up into the input channel.
   int  recv_stall;
   int  stall_draw;
   int  hold_left;
   bit  recv_burst;
   bin_mag_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
         hold_left <= 0;
         recv_burst <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bins_due.size() == 0) begin
               report_mismatch($sformatf("unexpected bin beat frame %0d bin %0d",
                                         rsp_bus.frame_index, rsp_bus.bin_index));
            end else begin
               want = bins_due.pop_front();
               if (rsp_bus.frame_index !== want.frame_index)
                  report_mismatch($sformatf("frame_index %0d, want %0d",
                                            rsp_bus.frame_index, want.frame_index));
               if (rsp_bus.bin_index !== want.bin_index)
                  report_mismatch($sformatf("bin_index %0d, want %0d",
                                            rsp_bus.bin_index, want.bin_index));
               if (rsp_bus.magnitude !== want.magnitude)
                  report_mismatch($sformatf("magnitude %0d, want %0d (bin %0d)",
                                            rsp_bus.magnitude, want.magnitude,
                                            want.bin_index));
               if (rsp_bus.last_bin !== want.last_bin)
                  report_mismatch($sformatf("last_bin %0b, want %0b (bin %0d)",
                                            rsp_bus.last_bin, want.last_bin,
                                            want.bin_index));
            end
         end
         if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            if ($urandom_range(0, 29) == 0) recv_burst <= !recv_burst;
            stall_draw = recv_burst ? 0 : $urandom_range(0, 18);
            recv_stall <= stall_draw;
            rsp_bus.ready <= (stall_draw == 0);
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_bus.ready <= (recv_stall == 1);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted beat on either channel restarts the count.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", HANG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic audio_beat_type audio_sample(input bit first, input int value);
      audio_beat_type b;
      b.kind          = KIND_SAMPLE;
      b.first_of_clip = first;
      b.sample        = value[15:0];
      b.entry_index   = 6'($urandom);
      b.coefficient   = 16'($urandom);
      return b;
   endfunction

   function automatic audio_beat_type window_write(input int idx, input int coef);
      audio_beat_type b;
      b.kind          = KIND_WINDOW;
      b.first_of_clip = $urandom_range(0, 1);
      b.sample        = 16'($urandom);
      b.entry_index   = idx[5:0];
      b.coefficient   = coef[15:0];
      return b;
   endfunction

   // Random sample value: mostly full range, sometimes small or at a rail.
   function automatic int random_level();
      case ($urandom_range(0, 5))
         0:       return -32768;
         1:       return 32767;
         2:       return $urandom_range(0, 400) - 200;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   // Random window coefficient, occasionally above unity.
   function automatic int random_coef();
      if ($urandom_range(0, 9) == 0) return $urandom_range(32769, 65535);
      return $urandom_range(0, 32768);
   endfunction

   // Mostly samples with the odd window rewrite and clip restart mixed in.
   task automatic queue_random(input int count, input int restart_odds);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            pending_beats.push_back(window_write($urandom_range(0, 63), random_coef()));
         else
            pending_beats.push_back(audio_sample($urandom_range(0, restart_odds) == 0,
                                                 random_level()));
      end
   endtask

   // Waits until every beat is taken and every bin has come back, then gives the
   // block time to finish any beat that produced no result. The check is made on
   // the falling edge so that the driver's updates of the same rising edge are seen.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_bus.valid || bins_due.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HOP_SIZE) hop_cfg = value & 8'h7F;
      else if (idx == CSR_FRAMES_PER_CLIP) clip_frames_cfg = value & 16'hFFFF;
   endtask

   task automatic set_phase(input int hop, input int clip_frames);
      wait_drained();
      write_csr(CSR_HOP_SIZE, hop);
      write_csr(CSR_FRAMES_PER_CLIP, clip_frames);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_SAMPLE;
      req_bus.first_of_clip = 1'b0;
      req_bus.sample = '0;
      req_bus.entry_index = '0;
      req_bus.coefficient = '0;
      rsp_bus.ready = 1'b0;
      hop_cfg = 32;
      clip_frames_cfg = 499;
      fill_level = 0;
      samples_since = 0;
      frame_num = 0;
      foreach (window_coef[i]) window_coef[i] = 0;
      foreach (sample_hist[i]) sample_hist[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The whole window table is written before any frame can read it. The first
      // entries carry a zero, a unity and an above-unity coefficient.
      pending_beats.push_back(window_write(0, 0));
      pending_beats.push_back(window_write(1, 32768));
      pending_beats.push_back(window_write(2, 65535));
      for (int i = 3; i < FRAME_LEN; i++)
         pending_beats.push_back(window_write(i, random_coef()));

      // Directed samples under the reset register values: rails, a clip restart on the first
      // sample, and a window write whose random first-of-clip flag is ignored.
      pending_beats.push_back(audio_sample(1'b1, 32767));
      pending_beats.push_back(audio_sample(1'b0, -32768));
      pending_beats.push_back(window_write(63, 32768));
      for (int i = 0; i < 64; i++)
         pending_beats.push_back(audio_sample(1'b0, (i % 2) ? -32768 : 32767));

      // Hop of one, three frames per clip, carrying on from the full ring: a frame
      // waits while the receiver holds off, so the block fills and the input stalls.
      set_phase(1, 3);
      hold_requests++;
      queue_random(16, 1000);
      pending_beats[0].kind = KIND_SAMPLE;
      pending_beats[0].first_of_clip = 1'b0;

      // No frames at all.
      set_phase(64, 0);
      queue_random(20, 20);

      // Widest hop with the largest frame limit.
      set_phase(64, 65535);
      pending_beats.push_back(audio_sample(1'b1, 0));
      queue_random(80, 1000);

      // A hop of zero behaves as one: the ring is full, so the next sample fires.
      set_phase(0, 2);
      queue_random(10, 1000);

      // Hop beyond the nominal range: too few samples follow for another frame.
      set_phase(127, 3);
      queue_random(20, 1000);

      // Random settings continuing the same clip, with the odd restart.
      for (int p = 0; p < 2; p++) begin
         set_phase($urandom_range(8, 40), $urandom_range(3, 6));
         queue_random(50, 60);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
